// File: rtl/sat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send sequence ack tracker package
// Shared widths, operation and event codes, and the structs that pass
// control between the sequencer, the slot store and the event output stage.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int WINDOW_SLOTS_DEF = 256;
	localparam int SEQ_MODULUS_DEF  = 2048;
	localparam int ACK_BITS_DEF     = 32;

	localparam int OP_W       = 2;
	localparam int KIND_W     = 2;
	localparam int SLOT_OUT_W = 8;
	localparam int SEQ_OUT_W  = 11;
	localparam int FLAGS_W    = 32;
	localparam int DROP_W     = 32;

	localparam logic [OP_W-1:0] OP_ISSUE = 2'd0;
	localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
	localparam logic [OP_W-1:0] OP_DROP  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	localparam logic [KIND_W-1:0] KIND_ISSUE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESEND = 2'd2;

	localparam logic [DROP_W-1:0] DROP_MAX = '1;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [SLOT_OUT_W-1:0] slot;
		logic [SEQ_OUT_W-1:0]  seq;
		logic [DROP_W-1:0]     drop;
	} evt_t;

	typedef struct packed {
		logic hit;
		logic fill;
		logic finish;
		evt_t evt;
	} evt_ctl_t;

	typedef struct packed {
		logic step_ok;
		logic fin_ok;
	} evt_sts_t;

	typedef struct packed {
		logic issue_we;
		logic ack_set;
		logic drop_clr;
	} store_op_t;

endpackage

// File: rtl/sat_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send sequence ack tracker channels
// Valid/ready channels for request words and event words.
// ----------------------------------------------------------------------------
interface sat_in_if;
	logic                         valid;
	logic                         ready;
	logic [sat_pkg::OP_W-1:0]     op;
	logic [sat_pkg::SEQ_OUT_W-1:0] ack_seq;
	logic [sat_pkg::FLAGS_W-1:0]  ack_flags;

	modport source (output valid, output op, output ack_seq, output ack_flags, input ready);
	modport sink (input valid, input op, input ack_seq, input ack_flags, output ready);
endinterface

interface sat_out_if;
	logic                           valid;
	logic                           ready;
	logic [sat_pkg::KIND_W-1:0]     event_kind;
	logic [sat_pkg::SLOT_OUT_W-1:0] slot;
	logic [sat_pkg::SEQ_OUT_W-1:0]  seq_number;
	logic [sat_pkg::DROP_W-1:0]     drop_total;
	logic                           last;

	modport source (output valid, output event_kind, output slot, output seq_number,
		output drop_total, output last, input ready);
	modport sink (input valid, input event_kind, input slot, input seq_number,
		input drop_total, input last, output ready);
endinterface

// File: rtl/sat_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot store
// Per-slot occupied and acked flags in flip-flops, and the stored sequence
// numbers in a memory with a registered read port.
// ----------------------------------------------------------------------------
module sat_slot_store #(
	parameter int WINDOW_SLOTS = sat_pkg::WINDOW_SLOTS_DEF,
	parameter int SEQ_W        = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sat_pkg::store_op_t              op,
	input  logic [$clog2(WINDOW_SLOTS)-1:0] addr,
	input  logic [SEQ_W-1:0]                wseq,
	output logic                            valid_bit,
	output logic                            acked_bit,
	output logic [SEQ_W-1:0]                rd_seq_q
);
	import sat_pkg::*;

	logic [WINDOW_SLOTS-1:0] valid_q;
	logic [WINDOW_SLOTS-1:0] acked_q;
	logic [SEQ_W-1:0]        seq_mem_q [WINDOW_SLOTS];

	assign valid_bit = valid_q[addr];
	assign acked_bit = acked_q[addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			acked_q <= '0;
		end else begin
			if (op.issue_we) begin
				valid_q[addr] <= 1'b1;
				acked_q[addr] <= 1'b0;
			end
			if (op.ack_set) begin
				acked_q[addr] <= 1'b1;
			end
			if (op.drop_clr) begin
				valid_q[addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.issue_we) begin
			seq_mem_q[addr] <= wseq;
		end
		rd_seq_q <= seq_mem_q[addr];
	end

endmodule

// File: rtl/sat_event_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event output stage
// Holds the newest event back by one so that the last flag is known, and
// drives the output register of the event channel.
// ----------------------------------------------------------------------------
module sat_event_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sat_pkg::evt_ctl_t                   ctl,
	input  logic [sat_pkg::SEQ_OUT_W-1:0]       rd_seq,
	output sat_pkg::evt_sts_t                   sts,
	sat_out_if.source                           evt
);
	import sat_pkg::*;

	logic pend_valid_q;
	logic fill_q;
	evt_t pend_q;
	evt_t pend_eff;
	logic out_valid_q;
	evt_t out_q;
	logic last_q;
	logic can_push;
	logic take_new;
	logic push;

	always_comb begin
		pend_eff = pend_q;
		if (fill_q) begin
			pend_eff.seq = rd_seq;
		end
	end

	assign can_push    = !out_valid_q || evt.ready;
	assign sts.step_ok = !(ctl.hit && pend_valid_q && !can_push);
	assign sts.fin_ok  = !pend_valid_q || can_push;
	assign take_new    = ctl.hit && sts.step_ok;
	assign push        = pend_valid_q && ((take_new) || (ctl.finish && can_push));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			fill_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take_new) begin
				pend_valid_q <= 1'b1;
				fill_q       <= ctl.fill;
			end else if (push) begin
				pend_valid_q <= 1'b0;
				fill_q       <= 1'b0;
			end else begin
				fill_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			pend_q <= ctl.evt;
		end else if (fill_q) begin
			pend_q.seq <= rd_seq;
		end
		if (push) begin
			out_q  <= pend_eff;
			last_q <= ctl.finish;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.event_kind = out_q.kind;
	assign evt.slot       = out_q.slot;
	assign evt.seq_number = out_q.seq;
	assign evt.drop_total = out_q.drop;
	assign evt.last       = last_q;

endmodule

// File: rtl/sat_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan sequencer
// Takes requests and walks the window one slot per cycle unless events stall,
// doing one read-modify-write of the slot flags per step and raising events.
// ----------------------------------------------------------------------------
module sat_sequencer #(
	parameter int WINDOW_SLOTS = sat_pkg::WINDOW_SLOTS_DEF,
	parameter int SEQ_MODULUS  = sat_pkg::SEQ_MODULUS_DEF,
	parameter int ACK_BITS     = sat_pkg::ACK_BITS_DEF,
	parameter int SEQ_W        = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sat_in_if.sink                          req,
	input  sat_pkg::evt_sts_t               sts,
	output sat_pkg::evt_ctl_t               ctl,
	output sat_pkg::store_op_t              sop,
	output logic [$clog2(WINDOW_SLOTS)-1:0] addr,
	output logic [SEQ_W-1:0]                wseq,
	input  logic                            valid_bit,
	input  logic                            acked_bit
);
	import sat_pkg::*;

	localparam int SLOT_W    = $clog2(WINDOW_SLOTS);
	localparam int CNT_W     = $clog2(ACK_BITS);
	localparam int RED_W     = (SEQ_W > SEQ_OUT_W) ? SEQ_W : SEQ_OUT_W;
	localparam int RED_STEPS = ((1 << SEQ_OUT_W) + SEQ_MODULUS - 1) / SEQ_MODULUS - 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ISSUE  = 3'd1;
	localparam logic [2:0] ST_ACK    = 3'd2;
	localparam logic [2:0] ST_DROP   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]          state_q;
	logic [SEQ_W-1:0]    cur_q;
	logic [SEQ_W-1:0]    idx_q;
	logic [SLOT_W-1:0]   scan_q;
	logic [ACK_BITS-1:0] flags_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DROP_W-1:0]   drop_q;
	logic [SEQ_W-1:0]    next_cur;
	logic [SEQ_W-1:0]    idx_dec;
	logic [RED_W-1:0]    red;
	logic [DROP_W-1:0]   drop_next;
	logic                acc;
	logic                step;
	logic                last_step;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign next_cur  = (cur_q == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : cur_q + 1'b1;
	assign idx_dec   = (idx_q == '0) ? SEQ_W'(SEQ_MODULUS - 1) : idx_q - 1'b1;
	assign drop_next = (drop_q == DROP_MAX) ? drop_q : drop_q + 1'b1;
	assign wseq      = next_cur;
	assign last_step = (cnt_q == CNT_W'(ACK_BITS - 1));

	always_comb begin
		red = RED_W'(req.ack_seq);
		for (int i = 0; i < RED_STEPS; i++) begin
			if (32'(red) >= SEQ_MODULUS) begin
				red = red - RED_W'(SEQ_MODULUS);
			end
		end
	end

	always_comb begin
		ctl        = '0;
		sop        = '0;
		addr       = scan_q;
		ctl.evt.drop = drop_q;
		case (state_q)
			ST_ISSUE: begin
				addr         = SLOT_W'(next_cur);
				ctl.hit      = 1'b1;
				ctl.evt.kind = KIND_ISSUE;
				ctl.evt.seq  = SEQ_OUT_W'(next_cur);
				sop.issue_we = sts.step_ok;
			end
			ST_ACK: begin
				addr         = SLOT_W'(idx_q);
				ctl.hit      = flags_q[0] && !acked_bit;
				ctl.evt.kind = KIND_ACK;
				ctl.evt.seq  = SEQ_OUT_W'(idx_q);
				sop.ack_set  = ctl.hit && sts.step_ok;
			end
			ST_DROP: begin
				ctl.hit      = valid_bit && !acked_bit;
				ctl.fill     = 1'b1;
				ctl.evt.kind = KIND_RESEND;
				ctl.evt.drop = drop_next;
				sop.drop_clr = ctl.hit && sts.step_ok;
			end
			ST_FINISH: begin
				ctl.finish = 1'b1;
			end
			default: begin
			end
		endcase
		ctl.evt.slot = SLOT_OUT_W'(addr);
	end

	assign step = ((state_q == ST_ACK) || (state_q == ST_DROP)) && sts.step_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			drop_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (acc) begin
						case (req.op)
							OP_ISSUE: state_q <= ST_ISSUE;
							OP_ACK:   state_q <= ST_ACK;
							OP_DROP:  state_q <= ST_DROP;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ISSUE: begin
					cur_q   <= next_cur;
					state_q <= ST_FINISH;
				end
				ST_ACK, ST_DROP: begin
					if (step) begin
						cnt_q <= cnt_q + 1'b1;
						if (last_step) begin
							state_q <= ST_FINISH;
						end
						if ((state_q == ST_DROP) && ctl.hit) begin
							drop_q <= drop_next;
						end
					end
				end
				ST_FINISH: begin
					if (sts.fin_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_q   <= SEQ_W'(red);
			flags_q <= ACK_BITS'(req.ack_flags);
			scan_q  <= SLOT_W'(32'(cur_q) + 32'd1);
		end else if (step) begin
			idx_q   <= idx_dec;
			flags_q <= flags_q >> 1;
			scan_q  <= scan_q + 1'b1;
		end
	end

endmodule

// File: rtl/send_sequence_ack_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send sequence ack tracker
// Sender-side reliability tracker over a window of sequence slots.
//
// Requests arrive as words on the req channel (issue, ack, drop check);
// events leave as words on the evt channel, the final event of a request
// carrying last. An issue gives one event; an ack or a drop check gives
// zero to ACK_BITS events. The block takes one request at a time.
// An issue passes through its issue and finish states before ready rises
// again; an ack or a drop check runs a scan that visits one window slot per
// cycle while the event stage does not stall, with one read-modify-write of
// the slot flags. Each event waits in the holding stage until the next event
// or the finish step moves it to the output register.
// When the receiver stalls, one event waits in the output register and one
// more in the holding stage; a further event stops the scan until the
// output register frees up.
// Reset empties all slots, clears the ack marks, the current sequence number
// and the drop counter at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module send_sequence_ack_tracker #(
	parameter int WINDOW_SLOTS = sat_pkg::WINDOW_SLOTS_DEF,
	parameter int SEQ_MODULUS  = sat_pkg::SEQ_MODULUS_DEF,
	parameter int ACK_BITS     = sat_pkg::ACK_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sat_in_if.sink    req,
	sat_out_if.source evt
);
	import sat_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_SLOTS);
	localparam int SEQ_W  = $clog2(SEQ_MODULUS);

	evt_ctl_t          ctl;
	evt_sts_t          sts;
	store_op_t         sop;
	logic [SLOT_W-1:0] addr;
	logic [SEQ_W-1:0]  wseq;
	logic [SEQ_W-1:0]  rd_seq;
	logic              valid_bit;
	logic              acked_bit;

	sat_sequencer #(
		.WINDOW_SLOTS (WINDOW_SLOTS),
		.SEQ_MODULUS  (SEQ_MODULUS),
		.ACK_BITS     (ACK_BITS),
		.SEQ_W        (SEQ_W)
	) u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.sts       (sts),
		.ctl       (ctl),
		.sop       (sop),
		.addr      (addr),
		.wseq      (wseq),
		.valid_bit (valid_bit),
		.acked_bit (acked_bit)
	);

	sat_slot_store #(
		.WINDOW_SLOTS (WINDOW_SLOTS),
		.SEQ_W        (SEQ_W)
	) u_slot_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (sop),
		.addr      (addr),
		.wseq      (wseq),
		.valid_bit (valid_bit),
		.acked_bit (acked_bit),
		.rd_seq_q  (rd_seq)
	);

	sat_event_out u_event_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_seq (SEQ_OUT_W'(rd_seq)),
		.sts    (sts),
		.evt    (evt)
	);

endmodule

// File: rtl/sat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send sequence ack tracker checker
// Port-level properties of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sat_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [sat_pkg::OP_W-1:0]       req_op,
	input logic                           evt_valid,
	input logic                           evt_ready,
	input logic [sat_pkg::KIND_W-1:0]     evt_kind,
	input logic [sat_pkg::SEQ_OUT_W-1:0]  evt_seq,
	input logic [sat_pkg::DROP_W-1:0]     evt_drop,
	input logic                           evt_last
);
	import sat_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_op != OP_NONE)) |=> !req_ready)
		else $error("Request accepted while a request is in progress.");

	a_issue_single: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && (evt_kind == KIND_ISSUE)) |-> evt_last)
		else $error("Issue word not marked as the last word.");

	a_resend_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && (evt_kind == KIND_RESEND)) |-> (evt_drop != '0))
		else $error("Resend word with a zero drop total.");

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && !evt_ready) |=> (evt_valid && $stable(evt_seq)))
		else $error("Stalled event word changed or dropped.");

endmodule

bind send_sequence_ack_tracker sat_checker u_sat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_op    (req.op),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.evt_kind  (evt.event_kind),
	.evt_seq   (evt.seq_number),
	.evt_drop  (evt.drop_total),
	.evt_last  (evt.last)
);

// File: tb/send_sequence_ack_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send sequence ack tracker event checker
// Watches the request and event channels of the tracker. Every accepted
// request word is run through a local model of the slot window, which
// queues the event words it should cause. Every accepted event word is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module send_sequence_ack_tracker_checker (
	input  logic        clk,
	input  logic        arst_n,
	sat_in_if           req,
	sat_out_if          evt,
	output int unsigned errors,
	output int unsigned outstanding
);
	import sat_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [SLOT_OUT_W-1:0] slot;
		logic [SEQ_OUT_W-1:0]  seq;
		logic [DROP_W-1:0]     drop;
		logic                  last;
	} tracker_event_t;

	logic [SEQ_OUT_W-1:0] cur_seq;
	logic [SEQ_OUT_W-1:0] slot_num [WINDOW_SLOTS_DEF];
	logic                 slot_full [WINDOW_SLOTS_DEF];
	logic                 slot_ack [WINDOW_SLOTS_DEF];
	logic [DROP_W-1:0]    drops;

	tracker_event_t pending_events[$];
	int unsigned    err_count;

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic predict_events(input logic [OP_W-1:0] op, input logic [SEQ_OUT_W-1:0] aseq,
		input logic [FLAGS_W-1:0] flags);
		tracker_event_t       batch[$];
		tracker_event_t       ev;
		logic [SEQ_OUT_W-1:0] idx;
		logic [7:0]           s;
		case (op)
			OP_ISSUE: begin
				cur_seq = cur_seq + 1'b1;
				s = cur_seq[7:0];
				slot_num[s] = cur_seq;
				slot_full[s] = 1'b1;
				slot_ack[s] = 1'b0;
				batch.push_back('{KIND_ISSUE, s, cur_seq, drops, 1'b0});
			end
			OP_ACK: begin
				idx = aseq;
				for (int i = 0; i < ACK_BITS_DEF; i++) begin
					s = idx[7:0];
					if (flags[i] && !slot_ack[s]) begin
						slot_ack[s] = 1'b1;
						batch.push_back('{KIND_ACK, s, idx, drops, 1'b0});
					end
					idx = idx - 1'b1;
				end
			end
			OP_DROP: begin
				s = cur_seq[7:0] + 8'd1;
				for (int i = 0; i < ACK_BITS_DEF; i++) begin
					if (slot_full[s] && !slot_ack[s]) begin
						if (drops != DROP_MAX)
							drops = drops + 1'b1;
						slot_full[s] = 1'b0;
						batch.push_back('{KIND_RESEND, s, slot_num[s], drops, 1'b0});
					end
					s = s + 8'd1;
				end
			end
			default: begin
			end
		endcase
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[k]) begin
			ev = batch[k];
			pending_events.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tracker_event_t want;
		if (!arst_n) begin
			cur_seq = '0;
			drops = '0;
			for (int i = 0; i < WINDOW_SLOTS_DEF; i++) begin
				slot_num[i] = '0;
				slot_full[i] = 1'b0;
				slot_ack[i] = 1'b0;
			end
			pending_events.delete();
			err_count = 0;
		end else begin
			if (evt.valid && evt.ready) begin
				if (pending_events.size() == 0) begin
					err_count++;
					$display("%0t: unexpected event word, expected none, actual kind %0d slot %0d seq %0d",
						$time, evt.event_kind, evt.slot, evt.seq_number);
				end else begin
					want = pending_events.pop_front();
					check_field("event_kind", want.kind, evt.event_kind);
					check_field("slot", want.slot, evt.slot);
					check_field("seq_number", want.seq, evt.seq_number);
					check_field("drop_total", want.drop, evt.drop_total);
					check_field("last", want.last, evt.last);
				end
			end
			if (req.valid && req.ready)
				predict_events(req.op, req.ack_seq, req.ack_flags);
		end
		errors <= err_count;
		outstanding <= pending_events.size();
	end

endmodule

// File: tb/send_sequence_ack_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send sequence ack tracker testbench
// Drives request words into the tracker and takes its event words with
// random stalls on both channels. A directed opening covers empty windows,
// repeated acks, wrapping ack walks and unknown operations; random traffic
// then issues, acks and drop-checks for 300 request words, so that resends
// occur. The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module send_sequence_ack_tracker_test;
	import sat_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	sat_in_if  req_ch ();
	sat_out_if evt_ch ();

	int unsigned mismatch_count;
	int unsigned waiting_count;

	int                   send_idle = 18;
	int                   recv_idle = 71;
	int unsigned          item_count = 0;
	logic [SEQ_OUT_W-1:0] tb_seq = '0;

	send_sequence_ack_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.evt    (evt_ch)
	);

	send_sequence_ack_tracker_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.evt         (evt_ch),
		.errors      (mismatch_count),
		.outstanding (waiting_count)
	);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("send_sequence_ack_tracker regression: fail");
		$finish;
	end

	initial begin
		evt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			evt_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [SEQ_OUT_W-1:0] aseq,
		input logic [FLAGS_W-1:0] flags);
		while ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.ack_seq <= aseq;
		req_ch.ack_flags <= flags;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		item_count++;
		if (op == OP_ISSUE)
			tb_seq = tb_seq + 1'b1;
	endtask

	initial begin
		int unsigned          pick;
		logic [FLAGS_W-1:0]   flags;
		logic [SEQ_OUT_W-1:0] aseq;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_NONE;
		req_ch.ack_seq <= '0;
		req_ch.ack_flags <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_NONE, 11'($urandom), $urandom);
		send_word(OP_DROP, '0, '0);
		send_word(OP_ACK, '0, '1);
		send_word(OP_ACK, '0, '1);
		repeat (6)
			send_word(OP_ISSUE, 11'($urandom), $urandom);
		send_word(OP_ACK, '1, '0);
		send_word(OP_ACK, '1, '1);
		send_word(OP_ACK, 11'd4, 32'h0000_0005);
		send_word(OP_ACK, 11'd5, 32'h8000_0000);
		send_word(OP_DROP, '1, '1);
		send_word(OP_NONE, '1, '1);
		send_word(OP_ISSUE, '1, '1);
		send_word(OP_ACK, tb_seq, 32'h0000_0001);
		send_word(OP_ACK, tb_seq, 32'h0000_0001);
		send_word(OP_ISSUE, '0, '0);
		send_word(OP_DROP, 11'($urandom), $urandom);

		item_count = 0;
		while (item_count < 300) begin
			if (item_count == 100) begin
				send_idle = 71;
				recv_idle = 18;
			end else if (item_count == 200) begin
				send_idle = 0;
				recv_idle = 0;
			end
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: flags = '0;
				1: flags = '1;
				2: flags = $urandom;
				default: flags = $urandom & $urandom;
			endcase
			if (pick < 60) begin
				send_word(OP_ISSUE, 11'($urandom), $urandom);
			end else if (pick < 80) begin
				aseq = tb_seq - 11'($urandom_range(0, 40));
				send_word(OP_ACK, aseq, flags);
			end else if (pick < 85) begin
				send_word(OP_ACK, 11'($urandom), flags);
			end else if (pick < 97) begin
				send_word(OP_DROP, 11'($urandom), $urandom);
			end else begin
				send_word(OP_NONE, 11'($urandom), $urandom);
			end
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (waiting_count != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("send_sequence_ack_tracker regression: pass");
		else
			$display("send_sequence_ack_tracker regression: fail");
		$finish;
	end

endmodule

// File: send_sequence_ack_tracker.f
rtl/sat_pkg.sv
rtl/sat_if.sv
rtl/sat_slot_store.sv
rtl/sat_event_out.sv
rtl/sat_sequencer.sv
rtl/send_sequence_ack_tracker.sv
rtl/sat_checker.sv
tb/send_sequence_ack_tracker_checker.sv
tb/send_sequence_ack_tracker_test.sv
